// ----- sv/jbt_pkg.sv -----
// ---------------------------------------------------------------------------
// jbt_pkg
// Shared types, codes and helpers for the JSON byte tokenizer.
// ---------------------------------------------------------------------------
package jbt_pkg;

   // result field widths
   localparam int IDX_W   = 11;
   localparam int POS_W   = 17;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // result kinds
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // token types
   localparam logic [1:0] TT_PRIM  = 2'd0;
   localparam logic [1:0] TT_STR   = 2'd1;
   localparam logic [1:0] TT_OBJ   = 2'd2;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_STRAY     = 3'd1,
      ERR_ESCAPE    = 3'd2,
      ERR_ILLEGAL   = 3'd3,
      ERR_FULL      = 3'd4,
      ERR_UNTERM    = 3'd5,
      ERR_TOO_LONG  = 3'd6
   } err_type;

   // scanner mode
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_PRIM = 2'd2
   } scan_mode_type;

   // escape phases
   localparam logic [2:0] ESC_NONE  = 3'd0;
   localparam logic [2:0] ESC_SLASH = 3'd1;
   localparam logic [2:0] ESC_HEX1  = 3'd2;
   localparam logic [2:0] ESC_HEX4  = 3'd5;

   // characters
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LBRC  = 8'h7B;
   localparam logic [7:0] CH_RBRC  = 8'h7D;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // one result word
   typedef struct packed {
      logic           last;
      logic [2:0]     err;
      logic [IDX_W-1:0] kids;
      logic [IDX_W-1:0] parent;
      logic [POS_W-1:0] tok_end;
      logic [POS_W-1:0] start;
      logic [1:0]     ttype;
      logic [IDX_W-1:0] idx;
      logic [1:0]     kind;
   } rsp_rec_type;

   // up to three results per byte
   typedef struct packed {
      logic [1:0]       cnt;
      rsp_rec_type [2:0] rec;
   } push_type;

   function automatic rsp_rec_type make_rec(
      input logic [1:0] kind, input logic [IDX_W-1:0] idx, input logic [1:0] ttype,
      input logic [POS_W-1:0] start, input logic [POS_W-1:0] tok_end,
      input logic [IDX_W-1:0] parent, input logic [IDX_W-1:0] kids,
      input logic [2:0] err);
      rsp_rec_type r;
      r.last    = 1'b0;
      r.err     = err;
      r.kids    = kids;
      r.parent  = parent;
      r.tok_end = tok_end;
      r.start   = start;
      r.ttype   = ttype;
      r.idx     = idx;
      r.kind    = kind;
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      case (c) inside
         8'h3A, 8'h2C, 8'h5D, 8'h7D, 8'h20, 8'h09, 8'h0D, 8'h0A: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      case (c) inside
         8'h3A, 8'h2C, 8'h20, 8'h09, 8'h0D, 8'h0A: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_simple_esc(input logic [7:0] c);
      case (c) inside
         8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

endpackage

// ----- sv/jbt_ctx_ram.sv -----
// ---------------------------------------------------------------------------
// jbt_ctx_ram
// Container context memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module jbt_ctx_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/jbt_scan.sv -----
// ---------------------------------------------------------------------------
// jbt_scan
// Byte scanner: token state, current and parent container registers, and
// the read-modify-write traffic to the container memory.
// ---------------------------------------------------------------------------
module jbt_scan #(
   parameter int MAX_TOKENS = 1024,
   parameter int MAX_BYTES  = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output jbt_pkg::push_type push
);
   import jbt_pkg::*;

   localparam int TW = $clog2(MAX_TOKENS);
   localparam int PW = $clog2(MAX_BYTES);
   localparam int EW = 1 + TW + PW + 1 + TW + 1;

   // stream counters
   logic [PW:0]   pos_ff, pos_in;
   logic [TW:0]   tu_ff, tu_in;
   logic          oc_v_ff, oc_v_in;
   logic [TW-1:0] oc_ff, oc_in;
   scan_mode_type mode_ff, mode_in;
   logic [2:0]    esc_ff, esc_in;
   logic [TW-1:0] pidx_ff, pidx_in;
   logic [PW:0]   pstart_ff, pstart_in;
   logic          lat_ff, lat_in;

   // current container
   logic          cpv_ff, cpv_in;
   logic [TW-1:0] cpi_ff, cpi_in;
   logic [PW-1:0] cst_ff, cst_in;
   logic          ckd_ff, ckd_in;
   logic [TW:0]   cch_ff, cch_in;

   // parent of current container
   logic          ppv_ff, ppv_in;
   logic [TW-1:0] ppi_ff, ppi_in;
   logic [PW-1:0] pst_ff, pst_in;
   logic          pkd_ff, pkd_in;
   logic [TW:0]   pch_ff, pch_in;
   logic          pend_ff, pend_in;

   // memory ports
   logic          mem_we, mem_re;
   logic [TW-1:0] mem_wa, mem_ra;
   logic [EW-1:0] mem_wd, mem_rd;

   // parent entry as seen this cycle
   logic          ev_pv, ev_kd;
   logic [TW-1:0] ev_pi;
   logic [PW-1:0] ev_st;
   logic [TW:0]   ev_ch;

   jbt_ctx_ram #(.DEPTH(MAX_TOKENS), .WIDTH(EW)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   // forward fresh read data over the held copy
   always_comb begin
      if (pend_ff) begin
         {ev_pv, ev_pi, ev_st, ev_kd, ev_ch} = mem_rd;
      end else begin
         ev_pv = ppv_ff; ev_pi = ppi_ff; ev_st = pst_ff; ev_kd = pkd_ff; ev_ch = pch_ff;
      end
   end

   // per-byte scan
   always_comb begin
      rsp_rec_type   recs [3];
      logic [1:0]    n;
      err_type       err;
      logic          do_btw;
      logic          clr;
      logic [TW:0]   kids;
      logic [IDX_W-1:0] par_o;
      logic [POS_W-1:0] pos_o;

      pos_in = pos_ff; tu_in = tu_ff; oc_v_in = oc_v_ff; oc_in = oc_ff;
      mode_in = mode_ff; esc_in = esc_ff; pidx_in = pidx_ff; pstart_in = pstart_ff;
      lat_in = lat_ff;
      cpv_in = cpv_ff; cpi_in = cpi_ff; cst_in = cst_ff; ckd_in = ckd_ff; cch_in = cch_ff;
      ppv_in = ppv_ff; ppi_in = ppi_ff; pst_in = pst_ff; pkd_in = pkd_ff; pch_in = pch_ff;
      pend_in = pend_ff;
      mem_we = 1'b0; mem_re = 1'b0; mem_wa = oc_ff; mem_ra = ev_pi;
      mem_wd = {cpv_ff, cpi_ff, cst_ff, ckd_ff, cch_ff};
      for (int i = 0; i < 3; i++) recs[i] = '0;
      n = 2'd0; err = ERR_NONE; do_btw = 1'b0; clr = 1'b0;
      kids = cch_ff;
      par_o = oc_v_ff ? IDX_W'(oc_ff) : '1;
      pos_o = POS_W'(pos_ff);

      if (in_fire) begin
         if (lat_ff) begin
            clr = in_last;
         end else begin
            if (pos_ff >= (PW+1)'(MAX_BYTES)) begin
               err = ERR_TOO_LONG;
            end else begin
               case (mode_ff)
                  MODE_PRIM: begin
                     if (is_delim(in_byte)) begin
                        recs[n] = make_rec(KIND_TOKEN, IDX_W'(pidx_ff), TT_PRIM,
                           POS_W'(pstart_ff), pos_o, par_o, '0, ERR_NONE);
                        n = n + 2'd1;
                        if (oc_v_ff) kids = kids + 1'b1;
                        mode_in = MODE_IDLE;
                        do_btw = 1'b1;
                     end else if (in_byte == CH_QUOTE || in_byte == CH_LBRC ||
                                  in_byte == CH_LBRK || in_byte < CH_SPACE) begin
                        err = ERR_ILLEGAL;
                     end
                  end
                  MODE_STR: begin
                     if (esc_ff == ESC_NONE && in_byte == CH_QUOTE) begin
                        recs[n] = make_rec(KIND_TOKEN, IDX_W'(pidx_ff), TT_STR,
                           POS_W'(pstart_ff), pos_o, par_o, '0, ERR_NONE);
                        n = n + 2'd1;
                        if (oc_v_ff) kids = kids + 1'b1;
                        mode_in = MODE_IDLE;
                     end else if (esc_ff == ESC_NONE) begin
                        if (in_byte == CH_BSL) esc_in = ESC_SLASH;
                        else if (in_byte < CH_SPACE) err = ERR_ILLEGAL;
                     end else if (esc_ff == ESC_SLASH) begin
                        if (in_byte == CH_U) esc_in = ESC_HEX1;
                        else if (is_simple_esc(in_byte)) esc_in = ESC_NONE;
                        else err = ERR_ESCAPE;
                     end else begin
                        if (!is_hex(in_byte)) err = ERR_ESCAPE;
                        else esc_in = (esc_ff >= ESC_HEX4) ? ESC_NONE : esc_ff + 3'd1;
                     end
                  end
                  default: do_btw = 1'b1;
               endcase
               cch_in = kids;

               if (do_btw) begin
                  if (in_byte == CH_LBRC || in_byte == CH_LBRK) begin
                     if (tu_ff >= (TW+1)'(MAX_TOKENS)) begin
                        err = ERR_FULL;
                     end else begin
                        // spill current container, it becomes the parent
                        mem_we = oc_v_ff;
                        mem_wd = {cpv_ff, cpi_ff, cst_ff, ckd_ff, kids + 1'b1};
                        ppv_in = cpv_ff; ppi_in = cpi_ff; pst_in = cst_ff;
                        pkd_in = ckd_ff; pch_in = kids + 1'b1; pend_in = 1'b0;
                        cpv_in = oc_v_ff; cpi_in = oc_ff; cst_in = pos_ff[PW-1:0];
                        ckd_in = (in_byte == CH_LBRK); cch_in = '0;
                        oc_v_in = 1'b1; oc_in = tu_ff[TW-1:0];
                        tu_in = tu_ff + 1'b1;
                     end
                  end else if (in_byte == CH_RBRC || in_byte == CH_RBRK) begin
                     if (!oc_v_ff) begin
                        err = ERR_STRAY;
                     end else begin
                        recs[n] = make_rec(KIND_TOKEN, IDX_W'(oc_ff), {1'b1, ckd_ff},
                           POS_W'(cst_ff), pos_o, cpv_ff ? IDX_W'(cpi_ff) : '1,
                           IDX_W'(kids), ERR_NONE);
                        n = n + 2'd1;
                        oc_v_in = cpv_ff; oc_in = cpi_ff;
                        if (cpv_ff) begin
                           // parent becomes current; fetch its parent
                           cpv_in = ev_pv; cpi_in = ev_pi; cst_in = ev_st;
                           ckd_in = ev_kd; cch_in = ev_ch;
                           mem_re = ev_pv; pend_in = ev_pv;
                        end
                     end
                  end else if (!is_sep(in_byte)) begin
                     if (tu_ff >= (TW+1)'(MAX_TOKENS)) begin
                        err = ERR_FULL;
                     end else if (in_byte != CH_QUOTE && in_byte < CH_SPACE) begin
                        err = ERR_ILLEGAL;
                     end else begin
                        pidx_in = tu_ff[TW-1:0];
                        tu_in = tu_ff + 1'b1;
                        if (in_byte == CH_QUOTE) begin
                           pstart_in = pos_ff + 1'b1;
                           mode_in = MODE_STR;
                           esc_in = ESC_NONE;
                        end else begin
                           pstart_in = pos_ff;
                           mode_in = MODE_PRIM;
                        end
                     end
                  end
               end
            end

            // end of stream
            if (err == ERR_NONE) begin
               pos_in = pos_ff + 1'b1;
               if (in_last) begin
                  if (mode_in == MODE_PRIM) begin
                     recs[n] = make_rec(KIND_TOKEN, IDX_W'(pidx_in), TT_PRIM,
                        POS_W'(pstart_in), POS_W'(pos_in),
                        oc_v_in ? IDX_W'(oc_in) : '1, '0, ERR_NONE);
                     n = n + 2'd1;
                  end
                  if (mode_in == MODE_STR || oc_v_in) begin
                     err = ERR_UNTERM;
                  end else begin
                     recs[n] = make_rec(KIND_DONE, IDX_W'(tu_in), TT_PRIM, '0, '0, '0, '0,
                        ERR_NONE);
                     n = n + 2'd1;
                  end
               end
            end

            if (err != ERR_NONE) begin
               recs[n] = make_rec(KIND_ERROR, '0, TT_PRIM, '0, '0, '0, '0, err);
               n = n + 2'd1;
               if (in_last) clr = 1'b1;
               else lat_in = 1'b1;
            end else if (in_last) begin
               clr = 1'b1;
            end
         end
      end

      if (n != 2'd0) recs[n - 2'd1].last = 1'b1;

      if (clr) begin
         pos_in = '0; tu_in = '0; oc_v_in = 1'b0; mode_in = MODE_IDLE;
         esc_in = ESC_NONE; pidx_in = '0; pstart_in = '0; lat_in = 1'b0;
         pend_in = 1'b0;
      end

      push.cnt = n;
      for (int i = 0; i < 3; i++) push.rec[i] = recs[i];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; tu_ff <= '0; oc_v_ff <= 1'b0; mode_ff <= MODE_IDLE;
         esc_ff <= ESC_NONE; pidx_ff <= '0; pstart_ff <= '0; lat_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; tu_ff <= tu_in; oc_v_ff <= oc_v_in; mode_ff <= mode_in;
         esc_ff <= esc_in; pidx_ff <= pidx_in; pstart_ff <= pstart_in; lat_ff <= lat_in;
         pend_ff <= pend_in;
      end
   end

   // container payload registers
   always_ff @(posedge clock) begin
      oc_ff <= oc_in;
      cpv_ff <= cpv_in; cpi_ff <= cpi_in; cst_ff <= cst_in; ckd_ff <= ckd_in;
      cch_ff <= cch_in;
      ppv_ff <= ppv_in; ppi_ff <= ppi_in; pst_ff <= pst_in; pkd_ff <= pkd_in;
      pch_ff <= pch_in;
   end

   // a byte never both spills and fetches
   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re)) else $error("spill and fetch in one cycle");

   // a pending fetch only exists under an open container
   a_pend_open: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> oc_v_ff) else $error("pending parent fetch with no container");

   // token counter stays within table
   a_tu_range: assert property (@(posedge clock) disable iff (reset)
      tu_ff <= (TW+1)'(MAX_TOKENS)) else $error("token count past table");

endmodule

// ----- sv/jbt_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// jbt_rsp_fifo
// Result queue: takes up to three words per cycle, hands out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module jbt_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  jbt_pkg::push_type    push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output jbt_pkg::rsp_rec_type out_rec
);
   import jbt_pkg::*;

   rsp_rec_type          q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_rec   = q_ff[rp_ff];
   assign room      = (cnt_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 3));

   // pointer update
   always_comb begin
      wp_in  = wp_ff + FIFO_AW'(push.cnt);
      rp_in  = rp_ff + FIFO_AW'(pop);
      cnt_in = cnt_ff + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.cnt) begin
            q_ff[wp_ff + FIFO_AW'(i)] <= push.rec[i];
         end
      end
   end

endmodule

// ----- sv/json_byte_tokenizer_core.sv -----
// ---------------------------------------------------------------------------
// json_byte_tokenizer_core
// Streaming JSON tokenizer: one byte per word in, token records out.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room for three
//   words; results drain at one word per cycle while rsp_tready is high.
// Results: a byte's words are written into the registered result queue.
// Open containers spill to a context RAM; a closer reuses a prefetched parent.
// Reset: synchronous, clears counters, queue and scan state; the context RAM
//   is not cleared.
module json_byte_tokenizer_core #(
   parameter int MAX_TOKENS = 1024,
   parameter int MAX_BYTES  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // token_index, token_type, token_start,
                                    // token_end, token_parent, child_count, error_code
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last_result
);
   import jbt_pkg::*;

   push_type    push;
   rsp_rec_type head;
   logic        room;
   logic        in_fire;

   assign req_tready = room;
   assign in_fire    = req_tvalid && room;

   jbt_scan #(.MAX_TOKENS(MAX_TOKENS), .MAX_BYTES(MAX_BYTES)) u_scan (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push)
   );

   jbt_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (head)
   );

   // result word packing
   assign rsp_tdata = {head.err, head.kids, head.parent, head.tok_end, head.start,
                       head.ttype, head.idx};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON byte tokenizer. Header bytes are streamed
// in as words. A behavioral tokenizer model predicts the token records,
// end-of-stream and error words, and every word that comes out is compared
// field by field. Both sides idle at random. Directed tests cover escapes,
// stray closers, bad escapes, illegal bytes, unterminated input and bytes
// dropped after an error. Random JSON streams, some of them corrupted, and
// raw noise follow.
// ---------------------------------------------------------------------------
module tb_top;
   import jbt_pkg::*;

   localparam int MAX_TOK  = 1024;
   localparam int MAX_LEN  = 65536;
   localparam int WD_LIMIT = 5000;
   localparam int HOLD_LEN = 300;
   localparam logic [1:0] TT_ARRAY = 2'd3;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   typedef struct {
      logic [1:0]  kind;
      logic [10:0] idx;
      logic [1:0]  ttype;
      logic [16:0] start;
      logic [16:0] tend;
      logic [10:0] parent;
      logic [10:0] kids;
      logic [2:0]  err;
      logic        last;
   } tok_word_type;

   tok_word_type expected_words[$];
   int  mismatches = 0;
   int  words_checked = 0;
   int  bytes_sent = 0;
   int  idle_cycles;
   int  rx_hold, hold_reqs, hold_seen;
   bit  no_idle;

   json_byte_tokenizer_core i_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- tokenizer model ----------------
   int          m_pos, m_used, m_open, m_pidx, m_pstart;
   int          m_mode, m_esc;
   bit          m_latched;
   int          c_parent[MAX_TOK];
   int          c_start[MAX_TOK];
   bit          c_is_array[MAX_TOK];
   int          c_kids[MAX_TOK];
   tok_word_type step_words[$];

   function automatic void clear_stream();
      m_pos = 0; m_used = 0; m_open = -1; m_pidx = 0; m_pstart = 0;
      m_mode = MODE_IDLE; m_esc = ESC_NONE; m_latched = 0;
   endfunction

   function automatic void add_word(logic [1:0] kind, int idx, logic [1:0] tt, int start,
                                    int tend, int parent, int kids, err_type err);
      tok_word_type w;
      w.kind = kind; w.idx = idx[10:0]; w.ttype = tt; w.start = start[16:0];
      w.tend = tend[16:0]; w.parent = parent[10:0]; w.kids = kids[10:0];
      w.err = err; w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void close_scalar(logic [1:0] tt, int tend);
      add_word(KIND_TOKEN, m_pidx, tt, m_pstart, tend, m_open, 0, ERR_NONE);
      if (m_open >= 0) c_kids[m_open]++;
      m_mode = MODE_IDLE;
   endfunction

   function automatic bit is_ws_sep(logic [7:0] c);
      return c == CH_COLON || c == CH_COMMA || c == CH_SPACE || c == 8'h09 ||
             c == 8'h0D || c == 8'h0A;
   endfunction

   // byte seen outside any string or primitive
   function automatic err_type outside_token(logic [7:0] c);
      int k;
      if (c == CH_LBRC || c == CH_LBRK) begin
         if (m_used >= MAX_TOK) return ERR_FULL;
         c_parent[m_used] = m_open;
         c_start[m_used] = m_pos;
         c_is_array[m_used] = (c == CH_LBRK);
         c_kids[m_used] = 0;
         if (m_open >= 0) c_kids[m_open]++;
         m_open = m_used;
         m_used++;
      end else if (c == CH_RBRC || c == CH_RBRK) begin
         k = m_open;
         if (k < 0) return ERR_STRAY;
         add_word(KIND_TOKEN, k, c_is_array[k] ? TT_ARRAY : TT_OBJ, c_start[k], m_pos,
                  c_parent[k], c_kids[k], ERR_NONE);
         m_open = c_parent[k];
      end else if (!is_ws_sep(c)) begin
         if (m_used >= MAX_TOK) return ERR_FULL;
         if (c != CH_QUOTE && c < 8'd32) return ERR_ILLEGAL;
         m_pidx = m_used;
         m_used++;
         if (c == CH_QUOTE) begin
            m_pstart = m_pos + 1; m_mode = MODE_STR; m_esc = ESC_NONE;
         end else begin
            m_pstart = m_pos; m_mode = MODE_PRIM;
         end
      end
      return ERR_NONE;
   endfunction

   function automatic err_type string_byte(logic [7:0] c);
      if (m_esc == ESC_NONE) begin
         if (c == CH_BSL) m_esc = ESC_SLASH;
         else if (c < 8'd32) return ERR_ILLEGAL;
      end else if (m_esc == ESC_SLASH) begin
         if (c == CH_U) m_esc = ESC_HEX1;
         else if (c == CH_QUOTE || c == CH_BSL || c == 8'h2F || c == 8'h62 ||
                  c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74) m_esc = ESC_NONE;
         else return ERR_ESCAPE;
      end else begin
         if (!((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46))) return ERR_ESCAPE;
         m_esc = (m_esc >= ESC_HEX4) ? ESC_NONE : m_esc + 1;
      end
      return ERR_NONE;
   endfunction

   // predict the words caused by one accepted byte
   function automatic void tokenize_byte(logic [7:0] c, logic fin);
      err_type err = ERR_NONE;
      step_words.delete();
      if (m_latched) begin
         if (fin) clear_stream();
         return;
      end
      if (m_pos >= MAX_LEN) begin
         err = ERR_TOO_LONG;
      end else if (m_mode == MODE_PRIM) begin
         if (is_ws_sep(c) || c == CH_RBRC || c == CH_RBRK) begin
            close_scalar(TT_PRIM, m_pos);
            err = outside_token(c);
         end else if (c == CH_QUOTE || c == CH_LBRC || c == CH_LBRK || c < 8'd32) begin
            err = ERR_ILLEGAL;
         end
      end else if (m_mode == MODE_STR) begin
         if (m_esc == ESC_NONE && c == CH_QUOTE) close_scalar(TT_STR, m_pos);
         else err = string_byte(c);
      end else begin
         err = outside_token(c);
      end
      if (err == ERR_NONE) begin
         m_pos++;
         if (fin) begin
            if (m_mode == MODE_PRIM) close_scalar(TT_PRIM, m_pos);
            if (m_mode == MODE_STR || m_open != -1) err = ERR_UNTERM;
            else add_word(KIND_DONE, m_used, 2'd0, 0, 0, 0, 0, ERR_NONE);
         end
      end
      if (err != ERR_NONE) begin
         add_word(KIND_ERROR, 0, 2'd0, 0, 0, 0, 0, err);
         if (fin) clear_stream();
         else m_latched = 1;
      end else if (fin) begin
         clear_stream();
      end
      if (step_words.size() > 0) step_words[$].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endfunction

   // ---------------- monitors ----------------
   // input side: predict on every accepted word
   always @(posedge clock) begin
      if (reset) clear_stream();
      else if (req_tvalid && req_tready) tokenize_byte(req_tdata, req_tlast);
   end

   // output side: check against oldest expectation, drive tready
   always @(posedge clock) begin
      tok_word_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold <= 0;
         hold_seen <= hold_reqs;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word: tdata=%h tuser=%0d",
                                              rsp_tdata, rsp_tuser);
            end else begin
               e = expected_words.pop_front();
               if (rsp_tuser != e.kind || rsp_tdata[10:0] != e.idx ||
                   rsp_tdata[12:11] != e.ttype || rsp_tdata[29:13] != e.start ||
                   rsp_tdata[46:30] != e.tend || rsp_tdata[57:47] != e.parent ||
                   rsp_tdata[68:58] != e.kids || rsp_tdata[71:69] != e.err ||
                   rsp_tlast != e.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp kind=%0d idx=%0d type=%0d start=%0d end=%0d %s",
                              e.kind, e.idx, e.ttype, e.start, e.tend, "");
                     $display("          exp parent=%0d kids=%0d err=%0d last=%0d",
                              e.parent, e.kids, e.err, e.last);
                     $display("          got kind=%0d idx=%0d type=%0d start=%0d end=%0d",
                              rsp_tuser, rsp_tdata[10:0], rsp_tdata[12:11],
                              rsp_tdata[29:13], rsp_tdata[46:30]);
                     $display("          got parent=%0d kids=%0d err=%0d last=%0d",
                              rsp_tdata[57:47], rsp_tdata[68:58], rsp_tdata[71:69],
                              rsp_tlast);
                  end
               end
            end
         end
         // long hold-off starts on request, then counts down here
         if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            rx_hold <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 24);
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog expired, %0d words outstanding", expected_words.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- sender ----------------
   task automatic send_byte(logic [7:0] b, logic fin);
      if (!no_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(string s, bit fin = 1);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
   endtask

   task automatic send_queue(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // sender stops until every expected word has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // random well-formed value, depth limited
   task automatic gen_value(ref logic [7:0] q[$], input int depth);
      int n;
      logic [7:0] ch;
      case ($urandom_range(depth > 3 ? 3 : 5))
         0: begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) q.push_back(8'("0" + $urandom_range(9)));
         end
         1: begin
            q.push_back("t"); q.push_back("r"); q.push_back("u"); q.push_back("e");
         end
         2, 3: begin
            q.push_back(CH_QUOTE);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(5))
                  0: begin q.push_back(CH_BSL); q.push_back("n"); end
                  1: begin
                     q.push_back(CH_BSL); q.push_back(CH_U);
                     repeat (4) q.push_back(8'("A" + $urandom_range(5)));
                  end
                  default: begin
                     ch = 8'($urandom_range(126, 35));
                     q.push_back(ch == CH_BSL ? 8'("z") : ch);
                  end
               endcase
            end
            q.push_back(CH_QUOTE);
         end
         4: begin
            q.push_back(CH_LBRK);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i) q.push_back(CH_COMMA);
               gen_value(q, depth + 1);
            end
            q.push_back(CH_RBRK);
         end
         default: begin
            q.push_back(CH_LBRC);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i) q.push_back(CH_COMMA);
               q.push_back(CH_QUOTE); q.push_back("k"); q.push_back(CH_QUOTE);
               q.push_back(CH_COLON);
               if ($urandom_range(1)) q.push_back(CH_SPACE);
               gen_value(q, depth + 1);
            end
            q.push_back(CH_RBRC);
         end
      endcase
   endtask

   // ---------------- tests ----------------
   task automatic test_well_formed();
      send_text("{\"a\":[1,true,\"x\\n\\u00aF\\/\"],\"b\":{}}");
      send_text("42");
      send_text(" [ -1.5e3 ,null]\t\r\n");
      send_text("\"\\\"\\\\\\b\\f\\r\\t\"");
   endtask

   task automatic test_errors();
      send_text("]");
      send_text("\"\\q\"");
      send_text("\"\\u0g12\"");
      send_byte(CH_QUOTE, 0); send_byte(8'h01, 1);
      send_text("1{");
      send_text("1\"");
      send_byte(8'h00, 1);
      send_text("[1");
      send_text("\"open");
      send_text("{}}");              // error on the final byte itself
      send_text("}[1,2]x", 0);       // bytes after a latched error are dropped
      send_byte(8'hff, 0);
      send_byte(8'h00, 0);
      send_byte(8'hff, 1);
   endtask

   task automatic test_backpressure();
      logic [7:0] q[$];
      drain();
      hold_reqs++;
      no_idle = 1;
      q.push_back(CH_LBRK);
      for (int i = 0; i < 40; i++) begin
         q.push_back("1"); q.push_back(CH_COMMA);
      end
      q.push_back("2"); q.push_back(CH_RBRK);
      send_queue(q);
      no_idle = 0;
      drain();
   endtask

   task automatic test_random(int target);
      logic [7:0] q[$];
      int start_bytes = bytes_sent;
      int pick;
      while (bytes_sent - start_bytes < target) begin
         q.delete();
         pick = $urandom_range(99);
         if (pick < 70) begin
            gen_value(q, 0);
         end else if (pick < 90) begin
            gen_value(q, 0);
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
         end else begin
            repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255)));
         end
         // stretch without idle cycles in the middle of the random part
         no_idle = (bytes_sent - start_bytes > target / 4) &&
                   (bytes_sent - start_bytes < target * 3 / 4);
         send_queue(q);
      end
      no_idle = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      hold_reqs = 0; no_idle = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_well_formed();
      test_errors();
      test_backpressure();
      test_random(130);

      drain();
      repeat (20) @(posedge clock);
      $display("tokenized %0d header bytes and checked %0d result words", bytes_sent,
               words_checked);
      $display("covered escapes, stray, escape, illegal and unterminated errors, back-pressure");
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
